// ===== rtl/core/saq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saq_pkg
// Types and constants shared by the sorted alarm queue core and its cells.
// ----------------------------------------------------------------------------
package saq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TIME_W  = 40;
  localparam int ID_W    = 63;
  localparam int WAKE_W  = 27;
  localparam int PEND_W  = 5;
  localparam int SEC_W   = 17;

  localparam int MS_PER_S   = 1000;
  localparam int WAKE_CAP_S = 24 * 60 * 60;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_TICK   = 2'd3
  } saq_kind_t;

  typedef enum logic [0:0] {
    RES_STATUS = 1'b0,
    RES_FIRED  = 1'b1
  } saq_res_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PAST      = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } saq_status_t;

  typedef struct packed {
    saq_kind_t          kind;
    logic [TIME_W-1:0]  alarm_time;
    logic [ID_W-1:0]    alarm_id;
    logic [TIME_W-1:0]  now;
  } saq_in_t;

  typedef struct packed {
    saq_res_kind_t      result_kind;
    saq_status_t        status;
    logic [TIME_W-1:0]  fired_time;
    logic [ID_W-1:0]    fired_id;
    logic [WAKE_W-1:0]  wake_ms;
    logic [PEND_W-1:0]  pending_count;
    logic               last;
  } saq_out_t;

  typedef struct packed {
    logic [TIME_W-1:0]  alarm_time;
    logic [ID_W-1:0]    alarm_id;
  } saq_entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_CMP  = 3'd1,
    CELL_INS  = 3'd2,
    CELL_DEL  = 3'd3,
    CELL_SHL  = 3'd4
  } saq_cell_op_t;

  typedef struct packed {
    saq_cell_op_t       op;
    logic [TIME_W-1:0]  key;
    saq_entry_t         new_entry;
  } saq_cell_ctl_t;

endpackage

// ===== rtl/core/sorted_alarm_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_alarm_queue_core
// Sorted store of up to DEPTH alarms with insert, delete, clear and tick.
// ----------------------------------------------------------------------------
// Alarms sit in a chain of DEPTH cells in ascending time order; every cell
// compares its own time with the key into a register and then takes its
// neighbor's entry in the next cycle, so insert and delete cost the same
// at any fill level. An item is taken when start is high and busy is low.
// Each result is on out_item, marked by out_strobe for one cycle, and
// cannot be held off; each fired alarm of a tick follows its own head
// compare. Clear answers the cycle after it is taken and never raises busy.
// Delete passes through the compare and execute states; insert through
// compare, shift, then the states W1, W2 and EMIT that form the wake delay.
// Tick repeats a head compare and a shift of the whole chain for each alarm
// fired, then a head compare and the wake delay states. The last result of
// an item has last set and is on the ports as busy falls, or with busy already low.
// ----------------------------------------------------------------------------
module sorted_alarm_queue_core
  import saq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  saq_in_t  in_item,
  output logic     out_strobe,
  output saq_out_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_TCMP,
    S_TFIRE,
    S_W1,
    S_W2,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  saq_in_t            cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               due_r, due_nxt;
  saq_status_t        status_r, status_nxt;
  logic [TIME_W-1:0]  diff_r, diff_nxt;
  logic               empty_r, empty_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  saq_out_t           out_item_r, out_item_nxt;

  saq_cell_ctl_t      cell_ctl;
  saq_cell_op_t       cell_op;
  saq_entry_t         cell_entry [DEPTH];
  saq_entry_t         cell_prev  [DEPTH];
  saq_entry_t         cell_next  [DEPTH];
  logic [DEPTH-1:0]   lt_vec;
  logic [DEPTH-1:0]   eq_vec;
  logic [DEPTH-1:0]   prev_lt_vec;
  logic [DEPTH-1:0]   occ_vec;
  logic               any_eq;
  saq_entry_t         head;
  saq_entry_t         new_entry;

  function automatic saq_out_t status_item(saq_status_t st, logic [WAKE_W-1:0] wake,
                                           logic [CNT_W-1:0] cnt);
    saq_out_t            o;
    logic [CNT_W+PEND_W-1:0] ext;
    ext               = (CNT_W + PEND_W)'(cnt);
    o.result_kind     = RES_STATUS;
    o.status          = st;
    o.fired_time      = '0;
    o.fired_id        = '0;
    o.wake_ms         = wake;
    o.pending_count   = ext[PEND_W-1:0];
    o.last            = 1'b1;
    return o;
  endfunction

  function automatic saq_out_t fired_item(saq_entry_t e, logic [CNT_W-1:0] cnt);
    saq_out_t            o;
    logic [CNT_W+PEND_W-1:0] ext;
    ext               = (CNT_W + PEND_W)'(cnt);
    o.result_kind     = RES_FIRED;
    o.status          = ST_OK;
    o.fired_time      = e.alarm_time;
    o.fired_id        = e.alarm_id;
    o.wake_ms         = '0;
    o.pending_count   = ext[PEND_W-1:0];
    o.last            = 1'b0;
    return o;
  endfunction

  assign new_entry          = '{alarm_time: cmd_r.alarm_time, alarm_id: cmd_r.alarm_id};
  assign cell_ctl.op        = cell_op;
  assign cell_ctl.key       = cmd_r.alarm_time;
  assign cell_ctl.new_entry = new_entry;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign occ_vec[gi] = (CNT_W'(gi) < count_r);
      if (gi == 0) begin : g_first
        assign prev_lt_vec[gi] = 1'b1;
        assign cell_prev[gi]   = new_entry;
      end else begin : g_mid
        assign prev_lt_vec[gi] = lt_vec[gi-1];
        assign cell_prev[gi]   = cell_entry[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign cell_next[gi] = '0;
      end else begin : g_inner
        assign cell_next[gi] = cell_entry[gi+1];
      end
      saq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cell_ctl),
        .occ        (occ_vec[gi]),
        .prev_lt    (prev_lt_vec[gi]),
        .prev_entry (cell_prev[gi]),
        .next_entry (cell_next[gi]),
        .entry      (cell_entry[gi]),
        .lt         (lt_vec[gi]),
        .eq         (eq_vec[gi])
      );
    end
  endgenerate

  assign any_eq = |eq_vec;
  assign head   = cell_entry[0];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    due_nxt        = due_r;
    status_nxt     = status_r;
    diff_nxt       = diff_r;
    empty_nxt      = empty_r;
    sec_nxt        = sec_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    cell_op        = CELL_HOLD;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_item;
          case (in_item.kind)
            KIND_INSERT, KIND_DELETE: begin
              state_nxt = S_CMP;
            end
            KIND_CLEAR: begin
              count_nxt      = '0;
              out_strobe_nxt = 1'b1;
              out_item_nxt   = status_item(ST_OK, '0, '0);
            end
            KIND_TICK: begin
              state_nxt = S_TCMP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CMP: begin
        cell_op   = CELL_CMP;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_r.kind == KIND_INSERT) begin
          if (!(cmd_r.alarm_time > cmd_r.now)) begin
            status_nxt = ST_PAST;
          end else if (any_eq) begin
            status_nxt = ST_OK;
          end else if (count_r >= CNT_W'(DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            cell_op    = CELL_INS;
            count_nxt  = count_r + CNT_W'(1);
            status_nxt = ST_OK;
          end
          state_nxt = S_W1;
        end else begin
          out_strobe_nxt = 1'b1;
          if (any_eq) begin
            cell_op      = CELL_DEL;
            count_nxt    = count_r - CNT_W'(1);
            out_item_nxt = status_item(ST_OK, '0, count_r - CNT_W'(1));
          end else begin
            out_item_nxt = status_item(ST_NOT_FOUND, '0, count_r);
          end
          state_nxt = S_IDLE;
        end
      end
      S_TCMP: begin
        due_nxt   = (count_r != '0) && (head.alarm_time <= cmd_r.now);
        state_nxt = S_TFIRE;
      end
      S_TFIRE: begin
        if (due_r) begin
          cell_op        = CELL_SHL;
          count_nxt      = count_r - CNT_W'(1);
          out_strobe_nxt = 1'b1;
          out_item_nxt   = fired_item(head, count_r - CNT_W'(1));
          state_nxt      = S_TCMP;
        end else begin
          status_nxt = ST_OK;
          state_nxt  = S_W1;
        end
      end
      S_W1: begin
        diff_nxt  = (head.alarm_time > cmd_r.now) ? (head.alarm_time - cmd_r.now) : '0;
        empty_nxt = (count_r == '0);
        state_nxt = S_W2;
      end
      S_W2: begin
        if (diff_r <= TIME_W'(1)) begin
          sec_nxt = SEC_W'(1);
        end else if (diff_r > TIME_W'(WAKE_CAP_S)) begin
          sec_nxt = SEC_W'(WAKE_CAP_S);
        end else begin
          sec_nxt = diff_r[SEC_W-1:0];
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt   = status_item(status_r,
                                     empty_r ? '0 : WAKE_W'(sec_r) * WAKE_W'(MS_PER_S),
                                     count_r);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      due_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      due_r        <= due_nxt;
      out_strobe_r <= out_strobe_nxt;
      cmd_r        <= cmd_nxt;
      status_r     <= status_nxt;
      diff_r       <= diff_nxt;
      empty_r      <= empty_nxt;
      sec_r        <= sec_nxt;
      out_item_r   <= out_item_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("alarm count above depth");

  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.result_kind == RES_FIRED) |-> !out_item.last)
    else $error("fired item marked last");

  a_fire_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TFIRE && due_r) |-> (count_r != '0))
    else $error("fire from empty store");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == KIND_TICK) |=> (busy && !out_strobe))
    else $error("tick did not enter walk");
`endif

endmodule

// ===== rtl/core/saq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saq_cell
// One slot of the sorted chain: holds an alarm, compares it against the key
// and takes data from its left or right neighbor on insert and removal.
// ----------------------------------------------------------------------------
module saq_cell
  import saq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  saq_cell_ctl_t ctl,
  input  logic          occ,
  input  logic          prev_lt,
  input  saq_entry_t    prev_entry,
  input  saq_entry_t    next_entry,
  output saq_entry_t    entry,
  output logic          lt,
  output logic          eq
);

  saq_entry_t entry_r, entry_nxt;
  logic       lt_r, lt_nxt;
  logic       eq_r, eq_nxt;

  always_comb begin
    entry_nxt = entry_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    case (ctl.op)
      CELL_CMP: begin
        lt_nxt = occ && (entry_r.alarm_time < ctl.key);
        eq_nxt = occ && (entry_r.alarm_time == ctl.key);
      end
      CELL_INS: begin
        if (!lt_r) begin
          entry_nxt = prev_lt ? ctl.new_entry : prev_entry;
        end
      end
      CELL_DEL: begin
        if (!lt_r) begin
          entry_nxt = next_entry;
        end
      end
      CELL_SHL: begin
        entry_nxt = next_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

// ===== dv/saq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saq_checker
// Watches the command and result channels of the sorted alarm queue core,
// keeps its own sorted alarm store, and predicts the results of every item
// taken. Each result is compared field by field with the oldest prediction.
// Mismatches, unexpected results and the number of predictions still open
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module saq_checker
  import saq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  saq_in_t  in_item,
  input  logic     out_strobe,
  input  saq_out_t out_item,
  output int       n_fail,
  output int       n_waiting
);

  localparam int REPORT_MAX = 10;

  logic [TIME_W-1:0] alarm_at  [DEPTH];
  logic [ID_W-1:0]   alarm_tag [DEPTH];
  int                n_alarms = 0;
  saq_out_t          want_q[$];

  function automatic int find_alarm(logic [TIME_W-1:0] t);
    for (int i = 0; i < n_alarms; i++) begin
      if (alarm_at[i] == t) return i;
    end
    return -1;
  endfunction

  function automatic void drop_alarm(int pos);
    for (int i = pos; i + 1 < n_alarms; i++) begin
      alarm_at[i]  = alarm_at[i+1];
      alarm_tag[i] = alarm_tag[i+1];
    end
    if (n_alarms > 0) n_alarms--;
  endfunction

  function automatic saq_status_t insert_alarm(logic [TIME_W-1:0] t, logic [ID_W-1:0] id,
                                               logic [TIME_W-1:0] now);
    int pos;
    if (t <= now) return ST_PAST;
    if (find_alarm(t) >= 0) return ST_OK;
    if (n_alarms >= DEPTH) return ST_FULL;
    pos = 0;
    while (pos < n_alarms && alarm_at[pos] < t) pos++;
    for (int i = n_alarms; i > pos; i--) begin
      alarm_at[i]  = alarm_at[i-1];
      alarm_tag[i] = alarm_tag[i-1];
    end
    alarm_at[pos]  = t;
    alarm_tag[pos] = id;
    n_alarms++;
    return ST_OK;
  endfunction

  function automatic logic [WAKE_W-1:0] head_wake_ms(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] secs;
    logic [63:0]       ms;
    if (n_alarms == 0) return '0;
    secs = (alarm_at[0] > now) ? alarm_at[0] - now : '0;
    if (secs < TIME_W'(1)) secs = TIME_W'(1);
    if (secs > TIME_W'(WAKE_CAP_S)) secs = TIME_W'(WAKE_CAP_S);
    ms = 64'(secs) * 64'(MS_PER_S);
    return ms[WAKE_W-1:0];
  endfunction

  function automatic string fmt_result(saq_out_t r);
    return $sformatf("kind=%0d status=%0d time=%0h id=%0h wake_ms=%0d pending=%0d last=%0d",
                     r.result_kind, r.status, r.fired_time, r.fired_id, r.wake_ms,
                     r.pending_count, r.last);
  endfunction

  task automatic predict_item(saq_in_t it);
    saq_out_t stat;
    saq_out_t fired;
    int       pos;
    stat             = '0;
    stat.result_kind = RES_STATUS;
    stat.status      = ST_OK;
    stat.last        = 1'b1;
    case (it.kind)
      KIND_INSERT: begin
        stat.status  = insert_alarm(it.alarm_time, it.alarm_id, it.now);
        stat.wake_ms = head_wake_ms(it.now);
      end
      KIND_DELETE: begin
        pos = find_alarm(it.alarm_time);
        if (pos >= 0) begin
          drop_alarm(pos);
        end else begin
          stat.status = ST_NOT_FOUND;
        end
      end
      KIND_CLEAR: begin
        n_alarms = 0;
      end
      default: begin
        while (n_alarms > 0 && alarm_at[0] <= it.now) begin
          fired             = '0;
          fired.result_kind = RES_FIRED;
          fired.status      = ST_OK;
          fired.fired_time  = alarm_at[0];
          fired.fired_id    = alarm_tag[0];
          drop_alarm(0);
          fired.pending_count = PEND_W'(n_alarms);
          want_q.push_back(fired);
        end
        stat.wake_ms = head_wake_ms(it.now);
      end
    endcase
    stat.pending_count = PEND_W'(n_alarms);
    want_q.push_back(stat);
  endtask

  task automatic check_result(saq_out_t got);
    saq_out_t want;
    bit       bad;
    if (want_q.size() == 0) begin
      n_fail++;
      if (n_fail <= REPORT_MAX) $display("ERROR: unexpected result %s", fmt_result(got));
      return;
    end
    want = want_q.pop_front();
    bad  = (got.result_kind !== want.result_kind) || (got.status !== want.status) ||
           (got.fired_time !== want.fired_time) || (got.fired_id !== want.fired_id) ||
           (got.wake_ms !== want.wake_ms) || (got.pending_count !== want.pending_count) ||
           (got.last !== want.last);
    if (bad) begin
      n_fail++;
      if (n_fail <= REPORT_MAX) begin
        $display("ERROR: result mismatch at %0t", $realtime);
        $display("  expected %s", fmt_result(want));
        $display("  actual   %s", fmt_result(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_fail    = 0;
      n_waiting <= 0;
    end else begin
      if (start && !busy) predict_item(in_item);
      if (out_strobe) check_result(out_item);
      n_waiting <= want_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sorted alarm queue core. Runs a directed pass over the
// edge cases (past times, duplicate times, full store, stale head, wake
// delay cap, extreme field values), then random command sequences built
// around a running network time, with random gaps between items. A checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import saq_pkg::*;

  localparam int                N_RANDOM  = 445;
  localparam int                WATCHDOG  = 2000;
  localparam int                DRAIN     = 60;
  localparam logic [TIME_W-1:0] MAX_TIME  = '1;
  localparam logic [ID_W-1:0]   MAX_ID    = '1;
  localparam logic [TIME_W-1:0] BASE_TOP  = MAX_TIME - 40'd200000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  saq_in_t  in_item;
  logic     out_strobe;
  saq_out_t out_item;
  int       n_fail;
  int       n_waiting;
  int       idle_cycles = 0;
  bit       no_idle;

  logic [TIME_W-1:0] now_s;
  logic [TIME_W-1:0] seen_q[$];

  always #10 clk = ~clk;

  sorted_alarm_queue_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  saq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .n_fail     (n_fail),
    .n_waiting  (n_waiting)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [ID_W-1:0] rand_id();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ID_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0] >> $urandom_range(0, TIME_W - 1);
  endfunction

  function automatic logic [TIME_W-1:0] pick_seen();
    if (seen_q.size() == 0) return rand_time();
    return seen_q[$urandom_range(0, seen_q.size() - 1)];
  endfunction

  task automatic issue(saq_kind_t k, logic [TIME_W-1:0] t, logic [ID_W-1:0] id,
                       logic [TIME_W-1:0] nw);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= '{kind: k, alarm_time: t, alarm_id: id, now: nw};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] nw;
    saq_kind_t         k;
    int                sel;
    bit                fill_mode;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    no_idle   = 1'b0;
    fill_mode = 1'b0;
    now_s     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    issue(KIND_TICK,   '0,       '0,     '0);
    issue(KIND_INSERT, '0,       '0,     '0);
    issue(KIND_INSERT, MAX_TIME, MAX_ID, MAX_TIME - 1);
    issue(KIND_INSERT, MAX_TIME, '0,     '0);
    issue(KIND_DELETE, 40'd5,    MAX_ID, MAX_TIME);
    issue(KIND_DELETE, MAX_TIME, '0,     '0);
    issue(KIND_INSERT, 40'd10,   rand_id(), 40'd5);
    issue(KIND_INSERT, 40'd30,   rand_id(), 40'd5);
    issue(KIND_INSERT, 40'd40,   rand_id(), 40'd15);
    for (int i = 0; i < DEPTH - 3; i++) begin
      issue(KIND_INSERT, 40'd86500 - 40'(10 * i), rand_id(), '0);
    end
    issue(KIND_INSERT, 40'd86450, rand_id(), '0);
    issue(KIND_INSERT, 40'd7,     rand_id(), '0);
    issue(KIND_TICK,   rand_time(), rand_id(), 40'd86400);
    issue(KIND_TICK,   rand_time(), rand_id(), MAX_TIME);
    issue(KIND_CLEAR,  MAX_TIME,  MAX_ID,   MAX_TIME);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          now_s = BASE_TOP - $urandom_range(0, 1000);
        end else begin
          now_s = rand_time();
          if (now_s > BASE_TOP) now_s = BASE_TOP;
        end
        fill_mode = ($urandom_range(0, 2) == 0);
      end
      if (n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (fill_mode && sel >= 48 && sel < 90 && $urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 33);
      end
      t  = rand_time();
      nw = now_s;
      k  = KIND_INSERT;
      if (sel < 30) begin
        t = now_s + $urandom_range(1, 120);
      end else if (sel < 34) begin
        t = now_s + $urandom_range(86000, 90000);
      end else if (sel < 40) begin
        t = pick_seen();
      end else if (sel < 45) begin
        t = now_s - $urandom_range(0, (now_s < 50) ? int'(now_s) : 50);
      end else if (sel < 48) begin
        k = KIND_INSERT;
      end else if (sel < 62) begin
        k = KIND_DELETE;
        if ($urandom_range(0, 3) != 0) t = pick_seen();
      end else if (sel < 90) begin
        k     = KIND_TICK;
        now_s = now_s + $urandom_range(0, (sel < 87) ? 40 : 300);
        nw    = now_s;
      end else if (sel < 94) begin
        k = KIND_CLEAR;
      end else begin
        k  = saq_kind_t'($urandom_range(0, 3));
        nw = rand_time();
      end
      if (k == KIND_INSERT) begin
        seen_q.push_back(t);
        if (seen_q.size() > 40) void'(seen_q.pop_front());
      end
      issue(k, t, rand_id(), nw);
    end
    start <= 1'b0;

    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_fail == 0 && n_waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
